FILE: rtl/epso_pkg.sv
// shared types, register indexes and table generators for the exp-pitch sine oscillator
// no dependencies; imported by every module of the block
package epso_pkg;

   localparam int DEF_PHASE_BITS      = 32;
   localparam int DEF_SINE_TABLE_BITS = 10;
   localparam int DEF_EXP_TABLE_BITS  = 10;
   localparam int MAX_EXP_TABLE_BITS  = 12;

   localparam int PITCH_W  = 15;
   localparam int SAMPLE_W = 16;
   localparam int CSR_W    = 32;
   localparam int SHIFT_W  = 6;

   // register indexes on the csr port
   localparam logic REG_KNOB_OFFSET     = 1'b0;
   localparam logic REG_BASE_PHASE_STEP = 1'b1;

   localparam logic [31:0] BASE_STEP_RESET = 32'd25480160;

   // pitch clamp, +-6 V in 1/1024 V
   localparam logic signed [15:0] PITCH_HI = 16'sd6144;
   localparam logic signed [15:0] PITCH_LO = -16'sd6144;

   // 2^(2^-j), j = 1..12, q1.31
   localparam logic [31:0] ROOT_TWO_Q31 [MAX_EXP_TABLE_BITS] = '{
      32'd3037000500, 32'd2553802834, 32'd2341847524, 32'd2242560872,
      32'd2194507417, 32'd2170868212, 32'd2159144272, 32'd2153306067,
      32'd2150392887, 32'd2148937775, 32'd2148210589, 32'd2147847088
   };

   // taylor coefficients of sin(pi/2 x), q30 magnitudes
   localparam logic [63:0] SINE_COEF_Q30 [5] = '{
      64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272
   };

   typedef struct packed {
      logic adv;   // pipeline moves this cycle
      logic vld;   // word present at the stage input
   } pipe_ctl_type;

   // 2^(k / 2^tbits) in q1.31, one rounded product per set bit
   function automatic logic [31:0] exp_entry(input int tbits, input int k);
      logic [63:0] acc;
      int          b;
      acc = 64'd1 << 31;
      for (b = 0; b < MAX_EXP_TABLE_BITS; b++) begin
         if (b < tbits && ((k >> (tbits - 1 - b)) & 1) != 0) begin
            acc = (acc * {32'd0, ROOT_TWO_Q31[b]} + (64'd1 << 30)) >> 31;
         end
      end
      return acc[31:0];
   endfunction

   // quarter-wave sine at the middle of bin k, scaled to 32767
   function automatic logic [14:0] sine_entry(input int tbits, input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] y;
      logic [63:0] s;
      int          j;
      x  = 64'(2 * k + 1) << (29 - tbits);
      x2 = (x * x) >> 30;
      t  = SINE_COEF_Q30[4];
      for (j = 3; j >= 0; j--) begin
         t = SINE_COEF_Q30[j] - ((x2 * t) >> 30);
      end
      y = (x * t) >> 30;
      s = (y * 64'd32767 + (64'd1 << 29)) >> 30;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s[14:0];
   endfunction

endpackage

FILE: rtl/epso_step_gen.sv
// phase step generation: pitch clamp, exponent table, scale multiply, shift
// depends on epso_pkg
module epso_step_gen #(
   parameter int PHASE_BITS     = epso_pkg::DEF_PHASE_BITS,
   parameter int EXP_TABLE_BITS = epso_pkg::DEF_EXP_TABLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  epso_pkg::pipe_ctl_type              ctl,
   input  logic signed [epso_pkg::PITCH_W-1:0] pitch_cv,
   input  logic signed [epso_pkg::PITCH_W-1:0] knob_offset,
   input  logic [31:0]                         base_phase_step,
   output logic                                step_vld,
   output logic [PHASE_BITS-1:0]               step
);
   import epso_pkg::*;

   localparam int EXP_SIZE = 1 << EXP_TABLE_BITS;
   localparam int SH_BASE  = 69 - PHASE_BITS;

   logic [31:0] exp_rom [EXP_SIZE];

   for (genvar k = 0; k < EXP_SIZE; k++) begin : g_exp_rom
      assign exp_rom[k] = exp_entry(EXP_TABLE_BITS, k);
   end

   logic signed [15:0]        sum;
   logic signed [15:0]        clamped;
   logic [13:0]               u;
   logic [9:0]                frac;
   logic [EXP_TABLE_BITS-1:0] idx;

   logic                      v2_ff, v3_ff, v4_ff, v5_ff;
   logic [EXP_TABLE_BITS-1:0] idx_ff, idx_in;
   logic [SHIFT_W-1:0]        sh2_ff, sh2_in, sh3_ff, sh4_ff;
   logic [31:0]               exp_ff;
   logic [63:0]               prod_ff;
   logic [PHASE_BITS-1:0]     step_ff, step_in;

   always_comb begin
      sum = {knob_offset[PITCH_W-1], knob_offset} + {pitch_cv[PITCH_W-1], pitch_cv};
      if (sum > PITCH_HI) begin
         clamped = PITCH_HI;
      end else if (sum < PITCH_LO) begin
         clamped = PITCH_LO;
      end else begin
         clamped = sum;
      end
      u    = 14'(clamped - PITCH_LO);
      frac = u[9:0];
   end

   if (EXP_TABLE_BITS <= 10) begin : g_idx_trunc
      assign idx = frac[9 -: EXP_TABLE_BITS];
   end else begin : g_idx_pad
      assign idx = {frac, {(EXP_TABLE_BITS - 10){1'b0}}};
   end

   // right shift is 63 - whole - PHASE_BITS with whole = u/1024 - 6
   assign idx_in  = idx;
   assign sh2_in  = SHIFT_W'(SH_BASE) - {2'b00, u[13:10]};
   assign step_in = PHASE_BITS'(prod_ff >> sh4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (ctl.adv) begin
         v2_ff   <= ctl.vld;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         v5_ff   <= v4_ff;
         idx_ff  <= idx_in;
         sh2_ff  <= sh2_in;
         exp_ff  <= exp_rom[idx_ff];
         sh3_ff  <= sh2_ff;
         prod_ff <= {32'd0, base_phase_step} * {32'd0, exp_ff};
         sh4_ff  <= sh3_ff;
         step_ff <= step_in;
      end
   end

   assign step_vld = v5_ff;
   assign step     = step_ff;

endmodule

FILE: rtl/epso_wave.sv
// phase accumulator and quarter-wave sine lookup with quadrant folding
// depends on epso_pkg
module epso_wave #(
   parameter int PHASE_BITS      = epso_pkg::DEF_PHASE_BITS,
   parameter int SINE_TABLE_BITS = epso_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  epso_pkg::pipe_ctl_type                ctl,
   input  logic [PHASE_BITS-1:0]                 step,
   output logic                                  sample_vld,
   output logic signed [epso_pkg::SAMPLE_W-1:0]  sample
);
   import epso_pkg::*;

   localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;

   logic [14:0] sine_rom [SINE_SIZE];

   for (genvar k = 0; k < SINE_SIZE; k++) begin : g_sine_rom
      assign sine_rom[k] = sine_entry(SINE_TABLE_BITS, k);
   end

   logic [PHASE_BITS-1:0]      phase_ff, phase_in;
   logic                       v6_ff, v7_ff;
   logic [1:0]                 quad;
   logic [SINE_TABLE_BITS-1:0] sidx;
   logic [14:0]                sine_ff;
   logic                       neg_ff;

   assign phase_in = phase_ff + step;

   always_comb begin
      quad = phase_ff[PHASE_BITS-1 -: 2];
      sidx = phase_ff[PHASE_BITS-3 -: SINE_TABLE_BITS];
      // mirror in the falling quarters
      if (quad[0]) begin
         sidx = ~sidx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         v6_ff    <= 1'b0;
         v7_ff    <= 1'b0;
      end else if (ctl.adv) begin
         if (ctl.vld) begin
            phase_ff <= phase_in;
         end
         v6_ff   <= ctl.vld;
         v7_ff   <= v6_ff;
         sine_ff <= sine_rom[sidx];
         neg_ff  <= quad[1];
      end
   end

   assign sample_vld = v7_ff;
   assign sample     = neg_ff ? -$signed({1'b0, sine_ff}) : $signed({1'b0, sine_ff});

endmodule

FILE: rtl/exp_pitch_sine_oscillator_unit.sv
// top level of the exponential-pitch sine oscillator: csr registers, input
// register, output register with skid stage; uses epso_pkg, epso_step_gen, epso_wave
//
// Each word on req carries a pitch control voltage (1/1024 V per unit). It is
// added to the knob offset register, clamped to +-6 V, and turned into a phase
// step of base_phase_step * 2^pitch through a constant exponent table over the
// fractional volt, a 32x32 multiply and a shift by the whole volts. The step
// is added to a wrapping PHASE_BITS accumulator, whose top bits address a
// constant quarter-wave sine table; the folded, signed 16-bit sample goes out
// on rsp, 32767 meaning +5 V. One word is taken every clock cycle while
// req_tready is high; a word's sample reaches rsp through eight register
// stages counting the input register that takes the word: input register,
// clamp, exponent table, multiply, shift, accumulate, sine table, output
// register. The only feedback path is the single phase add, so it does not
// hold back the next word; only a full skid slot stalls the whole pipeline.
// A skid stage behind the output register keeps req_tready independent of
// rsp_tready; req_tready drops only while both output slots are full.
// Configuration writes are taken in any cycle and should be made while idle.
module exp_pitch_sine_oscillator_unit #(
   parameter int PHASE_BITS      = epso_pkg::DEF_PHASE_BITS,
   parameter int SINE_TABLE_BITS = epso_pkg::DEF_SINE_TABLE_BITS,
   parameter int EXP_TABLE_BITS  = epso_pkg::DEF_EXP_TABLE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   // input stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,   // [14:0] pitch_cv, [15] zero
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,   // [15:0] sample
   // register writes
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [epso_pkg::CSR_W-1:0]  csr_wdata
);
   import epso_pkg::*;

   // configuration registers
   logic signed [PITCH_W-1:0] knob_ff;
   logic [31:0]               base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         knob_ff <= '0;
         base_ff <= BASE_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_KNOB_OFFSET:     knob_ff <= csr_wdata[PITCH_W-1:0];
            REG_BASE_PHASE_STEP: base_ff <= csr_wdata[31:0];
            default:             ;
         endcase
      end
   end

   // whole pipeline advances together unless the skid slot is occupied
   logic adv;
   logic skid_vld_ff;

   assign adv        = !skid_vld_ff;
   assign req_tready = adv;

   // input register
   logic                      v1_ff;
   logic signed [PITCH_W-1:0] cv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         cv_ff <= req_tdata[PITCH_W-1:0];
      end
   end

   pipe_ctl_type          step_ctl;
   pipe_ctl_type          wave_ctl;
   logic                  step_vld;
   logic [PHASE_BITS-1:0] step;
   logic                  sample_vld;
   logic signed [SAMPLE_W-1:0] sample;

   assign step_ctl = '{adv: adv, vld: v1_ff};
   assign wave_ctl = '{adv: adv, vld: step_vld};

   epso_step_gen #(
      .PHASE_BITS     (PHASE_BITS),
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_step_gen (
      .clock           (clock),
      .reset           (reset),
      .ctl             (step_ctl),
      .pitch_cv        (cv_ff),
      .knob_offset     (knob_ff),
      .base_phase_step (base_ff),
      .step_vld        (step_vld),
      .step            (step)
   );

   epso_wave #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_wave (
      .clock      (clock),
      .reset      (reset),
      .ctl        (wave_ctl),
      .step       (step),
      .sample_vld (sample_vld),
      .sample     (sample)
   );

   // output register plus one skid slot
   logic                out_vld_ff;
   logic [SAMPLE_W-1:0] out_data_ff;
   logic [SAMPLE_W-1:0] skid_data_ff;
   logic                out_take;
   logic                new_word;

   assign out_take = out_vld_ff && rsp_tready;
   assign new_word = adv && sample_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         // pipeline frozen, drain the skid slot first
         if (out_take) begin
            out_data_ff <= skid_data_ff;
            skid_vld_ff <= 1'b0;
         end
      end else if (new_word) begin
         if (!out_vld_ff || out_take) begin
            out_data_ff <= sample;
            out_vld_ff  <= 1'b1;
         end else begin
            skid_data_ff <= sample;
            skid_vld_ff  <= 1'b1;
         end
      end else if (out_take) begin
         out_vld_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // skid slot only fills behind a waiting output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid word without an output word");

   // a full skid slot stays full until the output word is taken
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !rsp_tready |=> skid_vld_ff && !req_tready)
      else $error("skid word lost while stalled");

   // the folded sine never reaches the most negative code
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 16'h8000)
      else $error("sample out of range");

endmodule
